// ===== sv/dtte_pkg.sv =====
// shared types, constants and lookup functions of the datetime text to epoch converter
`default_nettype none
package dtte_pkg;

  localparam int unsigned COUNT_WIDTH = 21;
  localparam logic [COUNT_WIDTH-1:0] MAX_RECORDS_RESET = COUNT_WIDTH'(1000000);

  localparam logic [4:0] LINE_LEN = 5'd29;
  localparam logic [4:0] POS_SAT  = 5'd30;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    CMD_CHAR = 2'd0,
    CMD_EOL  = 2'd1,
    CMD_EOF  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_SHAPE  = 3'd1,
    ST_NUMBER = 3'd2,
    ST_RANGE  = 3'd3,
    ST_ORDER  = 3'd4,
    ST_LIMIT  = 3'd5,
    ST_EMPTY  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    LERR_NONE   = 2'd0,
    LERR_SHAPE  = 2'd1,
    LERR_NUMBER = 2'd2
  } lerr_e;

  typedef enum logic [2:0] {
    FLD_YEAR   = 3'd0,
    FLD_MONTH  = 3'd1,
    FLD_DAY    = 3'd2,
    FLD_HOUR   = 3'd3,
    FLD_MINUTE = 3'd4,
    FLD_SECOND = 3'd5,
    FLD_FRAC   = 3'd6
  } fld_e;

  // controller to datapath
  typedef struct packed {
    logic       feed;
    logic       start;
    logic       is_eof;
    logic [4:0] calc;
    logic       emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic halts;
  } dp_sts_t;

  typedef struct packed {
    logic       is_sep;
    logic [7:0] sep_chr;
    fld_e       fld;
    logic       first;
    logic       last;
  } pos_info_t;

  function automatic pos_info_t pos_info(logic [4:0] p);
    pos_info_t r;
    r = '{is_sep: 1'b0, sep_chr: CH_MINUS, fld: FLD_FRAC, first: 1'b0, last: 1'b0};
    unique case (p)
      5'd0:  begin r.fld = FLD_YEAR; r.first = 1'b1; end
      5'd1, 5'd2: r.fld = FLD_YEAR;
      5'd3:  begin r.fld = FLD_YEAR; r.last = 1'b1; end
      5'd4:  begin r.is_sep = 1'b1; r.sep_chr = CH_MINUS; end
      5'd5:  begin r.fld = FLD_MONTH; r.first = 1'b1; end
      5'd6:  begin r.fld = FLD_MONTH; r.last = 1'b1; end
      5'd7:  begin r.is_sep = 1'b1; r.sep_chr = CH_MINUS; end
      5'd8:  begin r.fld = FLD_DAY; r.first = 1'b1; end
      5'd9:  begin r.fld = FLD_DAY; r.last = 1'b1; end
      5'd10: begin r.is_sep = 1'b1; r.sep_chr = CH_SPACE; end
      5'd11: begin r.fld = FLD_HOUR; r.first = 1'b1; end
      5'd12: begin r.fld = FLD_HOUR; r.last = 1'b1; end
      5'd13: begin r.is_sep = 1'b1; r.sep_chr = CH_COLON; end
      5'd14: begin r.fld = FLD_MINUTE; r.first = 1'b1; end
      5'd15: begin r.fld = FLD_MINUTE; r.last = 1'b1; end
      5'd16: begin r.is_sep = 1'b1; r.sep_chr = CH_COLON; end
      5'd17: begin r.fld = FLD_SECOND; r.first = 1'b1; end
      5'd18: begin r.fld = FLD_SECOND; r.last = 1'b1; end
      5'd19: begin r.is_sep = 1'b1; r.sep_chr = CH_DOT; end
      5'd20: begin r.fld = FLD_FRAC; r.first = 1'b1; end
      5'd28: begin r.fld = FLD_FRAC; r.last = 1'b1; end
      default: r.fld = FLD_FRAC;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_days(logic [3:0] m);
    logic [4:0] r;
    unique case (m)
      4'd2: r = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
      default: r = 5'd31;
    endcase
    return r;
  endfunction

  // days before the month in a year that starts in march
  function automatic logic [8:0] doy_base(logic [3:0] m);
    logic [8:0] r;
    unique case (m)
      4'd1:  r = 9'd306;
      4'd2:  r = 9'd337;
      4'd3:  r = 9'd0;
      4'd4:  r = 9'd31;
      4'd5:  r = 9'd61;
      4'd6:  r = 9'd92;
      4'd7:  r = 9'd122;
      4'd8:  r = 9'd153;
      4'd9:  r = 9'd184;
      4'd10: r = 9'd214;
      4'd11: r = 9'd245;
      4'd12: r = 9'd275;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/dtte_dp.sv =====
// datapath: character parser, days-from-civil conversion and result register
`default_nettype none
module dtte_dp (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [dtte_pkg::COUNT_WIDTH-1:0]   cfg_wdata_i,
  input  wire dtte_pkg::dp_cmd_t                  cmd_i,
  input  wire logic [7:0]                         char_i,
  output      dtte_pkg::dp_sts_t                  sts_o,
  output      logic [2:0]                         status_o,
  output      logic [63:0]                        epoch_o,
  output      logic [dtte_pkg::COUNT_WIDTH-1:0]   index_o
);

  localparam int unsigned CW = dtte_pkg::COUNT_WIDTH;

  // control state
  logic [CW-1:0]       max_q;
  logic [4:0]          pos_q, pos_d;
  dtte_pkg::lerr_e     lerr_q, lerr_d;
  logic [CW-1:0]       count_q;
  logic                have_last_q;
  logic                eof_q;

  // line payload
  logic [29:0]         acc_q, acc_d;
  logic                neg_q, neg_d, hasd_q, hasd_d;
  logic signed [14:0]  year_q;
  logic signed [7:0]   month_q, day_q, hour_q, minute_q, second_q;
  logic signed [30:0]  frac_q;
  logic [63:0]         last_q;

  // conversion pipeline
  logic signed [14:0]  y_q;
  logic [12:0]         xyr_q;
  logic [25:0]         prod_y_q, prod_yr_q;
  logic                bad_q;
  logic signed [24:0]  days_q;
  logic signed [42:0]  secs_q;
  logic                oor_q;
  logic [46:0]         p_lo_q;
  logic signed [48:0]  p_hi_q;
  logic [63:0]         u_q;

  // ---------------- character parser
  dtte_pkg::pos_info_t pi;
  logic                digit;
  logic [29:0]         acc_base;
  logic signed [30:0]  fval;

  always_comb begin
    pi       = dtte_pkg::pos_info(pos_q);
    digit    = (char_i >= dtte_pkg::CH_ZERO) && (char_i <= dtte_pkg::CH_NINE);
    acc_base = pi.first ? 30'd0 : acc_q;
    acc_d    = acc_q;
    neg_d    = neg_q;
    hasd_d   = hasd_q;
    lerr_d   = lerr_q;
    fval     = '0;
    if (pos_q >= dtte_pkg::LINE_LEN) begin
      lerr_d = dtte_pkg::LERR_SHAPE;
    end else if (pi.is_sep) begin
      if (char_i != pi.sep_chr) lerr_d = dtte_pkg::LERR_SHAPE;
    end else begin
      acc_d  = acc_base;
      neg_d  = pi.first ? 1'b0 : neg_q;
      hasd_d = pi.first ? 1'b0 : hasd_q;
      if (pi.first && char_i == dtte_pkg::CH_MINUS) begin
        neg_d = 1'b1;
      end else if (digit) begin
        acc_d  = 30'((acc_base << 3) + (acc_base << 1) + {22'd0, char_i - dtte_pkg::CH_ZERO});
        hasd_d = 1'b1;
      end else if (lerr_q == dtte_pkg::LERR_NONE) begin
        lerr_d = dtte_pkg::LERR_NUMBER;
      end
      if (pi.last && !hasd_d && lerr_d == dtte_pkg::LERR_NONE) lerr_d = dtte_pkg::LERR_NUMBER;
      fval = neg_d ? -$signed({1'b0, acc_d}) : $signed({1'b0, acc_d});
    end
    pos_d = (pos_q < dtte_pkg::POS_SAT) ? pos_q + 5'd1 : dtte_pkg::POS_SAT;
  end

  // ---------------- conversion steps
  // step 0: shifted year and reciprocal products for division by 25
  logic               mle2;
  logic signed [14:0] y_d;
  logic signed [12:0] qy, qyr;
  logic [13:0]        sum_y, sum_yr;

  always_comb begin
    mle2   = month_q <= 8'sd2;
    y_d    = year_q - $signed({14'd0, mle2});
    qy     = y_d[14:2];
    qyr    = year_q[14:2];
    sum_y  = 14'($signed({qy[12], qy}) + 14'sd2500);
    sum_yr = 14'($signed({qyr[12], qyr}) + 14'sd2500);
  end

  // step 1: leap year, range checks, day number
  logic [7:0]         d25y, d25yr;
  logic [12:0]        rem_yr;
  logic               leap, date_ok, time_ok;
  logic [4:0]         dim;
  logic signed [24:0] t365, q_ext, f100, f400, doy_ext, day_ext, days_d;

  always_comb begin
    d25y    = prod_y_q[24:17];
    d25yr   = prod_yr_q[24:17];
    rem_yr  = xyr_q - 13'({5'd0, d25yr} * 13'd25);
    leap    = (year_q[1:0] == 2'd0) && ((rem_yr != 13'd0) || (d25yr[1:0] == 2'd0));
    dim     = (month_q == 8'sd2 && leap) ? 5'd29 : dtte_pkg::month_days(month_q[3:0]);
    date_ok = (month_q >= 8'sd1) && (month_q <= 8'sd12) && (day_q >= 8'sd1) &&
              (day_q <= $signed({3'd0, dim}));
    time_ok = (hour_q >= 8'sd0) && (hour_q <= 8'sd23) && (minute_q >= 8'sd0) &&
              (minute_q <= 8'sd59) && (second_q >= 8'sd0) && (second_q <= 8'sd59) &&
              !frac_q[30];
    t365    = 25'(y_q) * 25'sd365;
    q_ext   = 25'(y_q >>> 2);
    f100    = $signed({17'd0, d25y}) - 25'sd100;
    f400    = $signed({19'd0, d25y[7:2]}) - 25'sd25;
    doy_ext = $signed({16'd0, dtte_pkg::doy_base(month_q[3:0])});
    day_ext = 25'(day_q);
    days_d  = t365 + q_ext - f100 + f400 + doy_ext + day_ext - 25'sd1 - 25'sd719468;
  end

  // step 2 and 3
  logic signed [42:0] secs_d;
  logic               oor_d;
  always_comb begin
    secs_d = 43'(days_q) * 43'sd86400 + 43'(hour_q) * 43'sd3600 +
             43'(minute_q) * 43'sd60 + 43'(second_q);
    oor_d  = (secs_q > 43'sd9223372036) ||
             (secs_q == 43'sd9223372036 && frac_q > 31'sd854775807) ||
             (secs_q < -43'sd9223372037) ||
             (secs_q == -43'sd9223372037 && frac_q < 31'sd145224192);
  end

  // ---------------- result decision
  dtte_pkg::status_e res_st;
  logic [63:0]       res_val;
  logic [CW-1:0]     res_idx, cnt_inc;
  logic              res_halts, res_upd;

  always_comb begin
    cnt_inc   = count_q + CW'(1);
    res_st    = dtte_pkg::ST_OK;
    res_val   = u_q;
    res_idx   = count_q;
    res_halts = eof_q;
    res_upd   = 1'b0;
    if (!eof_q || pos_q != 5'd0) begin
      priority if (count_q >= max_q) res_st = dtte_pkg::ST_LIMIT;
      else if (pos_q != dtte_pkg::LINE_LEN || lerr_q == dtte_pkg::LERR_SHAPE)
        res_st = dtte_pkg::ST_SHAPE;
      else if (lerr_q == dtte_pkg::LERR_NUMBER) res_st = dtte_pkg::ST_NUMBER;
      else if (bad_q || oor_q) res_st = dtte_pkg::ST_RANGE;
      else if (have_last_q && !($signed(u_q) > $signed(last_q))) res_st = dtte_pkg::ST_ORDER;
      else res_st = dtte_pkg::ST_OK;
      if (res_st != dtte_pkg::ST_OK) begin
        res_val   = '0;
        res_halts = 1'b1;
      end else begin
        res_upd = 1'b1;
        if (eof_q) res_idx = cnt_inc;
      end
    end else if (count_q == '0) begin
      res_st    = dtte_pkg::ST_EMPTY;
      res_val   = '0;
      res_idx   = '0;
      res_halts = 1'b1;
    end else begin
      res_val = last_q;
    end
  end

  assign sts_o.halts = res_halts;

  // ---------------- control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= dtte_pkg::MAX_RECORDS_RESET;
      pos_q       <= '0;
      lerr_q      <= dtte_pkg::LERR_NONE;
      count_q     <= '0;
      have_last_q <= 1'b0;
      eof_q       <= 1'b0;
    end else begin
      if (cfg_we_i) max_q <= cfg_wdata_i;
      if (cmd_i.feed) begin
        pos_q  <= pos_d;
        lerr_q <= lerr_d;
      end
      if (cmd_i.start) eof_q <= cmd_i.is_eof;
      if (cmd_i.emit) begin
        pos_q  <= '0;
        lerr_q <= dtte_pkg::LERR_NONE;
        if (res_upd) begin
          count_q     <= cnt_inc;
          have_last_q <= 1'b1;
        end
      end
    end
  end

  // ---------------- payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.feed && pos_q < dtte_pkg::LINE_LEN && !pi.is_sep) begin
      acc_q  <= acc_d;
      neg_q  <= neg_d;
      hasd_q <= hasd_d;
      if (pi.last) begin
        unique case (pi.fld)
          dtte_pkg::FLD_YEAR:   year_q   <= fval[14:0];
          dtte_pkg::FLD_MONTH:  month_q  <= fval[7:0];
          dtte_pkg::FLD_DAY:    day_q    <= fval[7:0];
          dtte_pkg::FLD_HOUR:   hour_q   <= fval[7:0];
          dtte_pkg::FLD_MINUTE: minute_q <= fval[7:0];
          dtte_pkg::FLD_SECOND: second_q <= fval[7:0];
          default:              frac_q   <= fval;
        endcase
      end
    end
    if (cmd_i.calc[0]) begin
      y_q       <= y_d;
      xyr_q     <= sum_yr[12:0];
      prod_y_q  <= {13'd0, sum_y[12:0]} * 26'd5243;
      prod_yr_q <= {13'd0, sum_yr[12:0]} * 26'd5243;
    end
    if (cmd_i.calc[1]) begin
      bad_q  <= !(date_ok && time_ok);
      days_q <= days_d;
    end
    if (cmd_i.calc[2]) secs_q <= secs_d;
    if (cmd_i.calc[3]) begin
      oor_q  <= oor_d;
      p_lo_q <= {30'd0, secs_q[16:0]} * 47'd1000000000;
      p_hi_q <= 49'($signed(secs_q[34:17])) * 49'sd1000000000;
    end
    if (cmd_i.calc[4]) begin
      u_q <= ({{15{p_hi_q[48]}}, p_hi_q} << 17) + {17'd0, p_lo_q} + {33'd0, frac_q};
    end
    if (cmd_i.emit) begin
      status_o <= res_st;
      epoch_o  <= res_val;
      index_o  <= res_idx;
      if (res_upd) last_q <= u_q;
      acc_q    <= '0;
      neg_q    <= 1'b0;
      hasd_q   <= 1'b0;
      year_q   <= '0;
      month_q  <= '0;
      day_q    <= '0;
      hour_q   <= '0;
      minute_q <= '0;
      second_q <= '0;
      frac_q   <= '0;
    end
  end

endmodule
`default_nettype wire

// ===== sv/dtte_ctrl.sv =====
// controller: handshakes, conversion sequencing, halt flag
`default_nettype none
module dtte_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [1:0]        in_cmd_i,
  output      logic              in_ready_o,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  input  wire dtte_pkg::dp_sts_t sts_i,
  output      dtte_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_C0, S_C1, S_C2, S_C3, S_C4, S_EMIT
  } state_e;

  state_e         state_q;
  logic           halted_q;
  logic           out_valid_q;
  logic           in_acc, load;
  dtte_pkg::cmd_e cmd;

  assign cmd        = dtte_pkg::cmd_e'(in_cmd_i);
  assign in_ready_o = state_q == S_IDLE;
  assign in_acc     = in_valid_i && in_ready_o;
  assign load       = state_q == S_EMIT && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o.feed   = in_acc && !halted_q && cmd == dtte_pkg::CMD_CHAR;
    cmd_o.start  = in_acc && !halted_q && (cmd == dtte_pkg::CMD_EOL || cmd == dtte_pkg::CMD_EOF);
    cmd_o.is_eof = cmd == dtte_pkg::CMD_EOF;
    cmd_o.calc   = {state_q == S_C4, state_q == S_C3, state_q == S_C2,
                    state_q == S_C1, state_q == S_C0};
    cmd_o.emit   = load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (cmd_o.start) state_q <= S_C0;
        S_C0:   state_q <= S_C1;
        S_C1:   state_q <= S_C2;
        S_C2:   state_q <= S_C3;
        S_C3:   state_q <= S_C4;
        S_C4:   state_q <= S_EMIT;
        S_EMIT: begin
          if (load) begin
            state_q  <= S_IDLE;
            halted_q <= sts_i.halts;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni) !$fell(halted_q))
    else $error("halt flag dropped without reset");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !cmd_o.emit)
    else $error("result register overwritten while full");
  a_rose_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_EMIT))
    else $error("result raised outside the emit step");
  a_line_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> (state_q == S_C0 && !in_ready_o))
    else $error("line end did not start conversion");
  a_calc_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.calc, cmd_o.feed}))
    else $error("parser and conversion active together");
`endif

endmodule
`default_nettype wire

// ===== sv/datetime_text_to_epoch_ns.sv =====
// top level of the datetime text to epoch nanoseconds converter
`default_nettype none
// Parses lines of the form YYYY-MM-DD HH:MM:SS.nnnnnnnnn arriving one character
// word per cycle on the slave stream (tuser selects character, end of line or end
// of file) and returns one result word per end of line, plus one at end of file.
// Character words are taken at one per cycle while idle and give no result. An
// end-of-line or end-of-file word starts a conversion (leap and range checks,
// days-from-civil, two split 1e9 multiplies, final add) during which the input
// is held off. The result sits in a one-word output register, so parsing of the
// next line carries on while it waits to be taken. Any error, or end of file,
// halts the block until reset; words arriving while halted are taken and dropped.
// max_records must be written through cfg_we_i/cfg_wdata_i only while the block
// is idle; the user must keep to this, the block itself does not enforce it.
module datetime_text_to_epoch_ns (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [dtte_pkg::COUNT_WIDTH-1:0] cfg_wdata_i,   // max_records
  input  wire logic                             s_axis_tvalid,
  output      logic                             s_axis_tready,
  input  wire logic [7:0]                       s_axis_tdata,  // [7:0] character
  input  wire logic [1:0]                       s_axis_tuser,  // [1:0] command
  output      logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [2:0] status, [66:3] epoch_nanoseconds, [87:67] record_index
  output      logic [87:0]                      m_axis_tdata
);

  dtte_pkg::dp_cmd_t                  cmd;
  dtte_pkg::dp_sts_t                  sts;
  logic [2:0]                         status;
  logic [63:0]                        epoch;
  logic [dtte_pkg::COUNT_WIDTH-1:0]   index;

  // sequencing and handshakes
  dtte_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_cmd_i    (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // parser, conversion and result register
  dtte_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .char_i      (s_axis_tdata),
    .sts_o       (sts),
    .status_o    (status),
    .epoch_o     (epoch),
    .index_o     (index)
  );

  // result word packing, first field lowest
  assign m_axis_tdata = {index, epoch, status};

endmodule
`default_nettype wire
